/* rtl/sfcrc_pkg.sv */
// Shared types, protocol constants and the CRC byte step for the sync-frame receiver.
package sfcrc_pkg;

    localparam logic [7:0]  SYNC_FIRST     = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND    = 8'h5A;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [7:0]  PROTO_VERSION  = 8'h01;
    localparam logic [7:0]  TYPE_VISION    = 8'h03;
    localparam logic [7:0]  TYPE_TARGET    = 8'h04;
    localparam int          LEN_VISION     = 8;
    localparam int          LEN_TARGET     = 4;
    localparam int          FRAME_OVERHEAD = 7;
    localparam logic [7:0]  STREAK_MAX     = 8'd255;
    localparam int          STORE_DEPTH    = 15;

    localparam logic [3:0] VISION_SIZE = 4'(FRAME_OVERHEAD + LEN_VISION);
    localparam logic [3:0] TARGET_SIZE = 4'(FRAME_OVERHEAD + LEN_TARGET);
    localparam logic [3:0] HEADER_END  = 4'd5;
    localparam logic [3:0] POS_LIMIT   = 4'(STORE_DEPTH);

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        EV_VISION_OK  = 3'd0,
        EV_TARGET_OK  = 3'd1,
        EV_VISION_CRC = 3'd2,
        EV_TARGET_CRC = 3'd3,
        EV_TARGET_FMT = 3'd4
    } event_kind_t;

    // Classified frame handed from the parser to the counter stage
    typedef struct packed {
        event_kind_t kind;
        logic [15:0] seq;
        logic [7:0]  flags;
        logic [7:0]  conf;
        logic [15:0] pos;
        logic [15:0] vel;
    } job_t;

    typedef struct packed {
        event_kind_t        event_kind;
        logic [15:0]        sequence_res;
        logic [7:0]         frame_flags;
        logic [7:0]         confidence;
        logic [15:0]        position_q4;
        logic signed [15:0] velocity;
        logic               sample_valid;
        logic [7:0]         valid_streak;
        logic [15:0]        sequence_drop_count;
        logic [15:0]        crc_error_count;
        logic [15:0]        format_error_count;
        logic [15:0]        update_count;
    } result_t;

    // One byte of CRC-16/CCITT-FALSE, MSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/sfcrc_fifo.sv */
// Small first-word-fall-through register queue.
module sfcrc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/sfcrc_front.sv */
// Byte parser: sync hunt, header checks, running CRC and frame classification.
module sfcrc_front
    import sfcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        opcode,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    input  logic [15:0] timeout_ms,
    output logic        job_valid,
    output job_t        job
);

    logic [7:0]  store_reg [STORE_DEPTH];
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  explen_reg, explen_next;
    logic [31:0] last_reg, last_next;
    logic [15:0] crc_reg, crc_next;
    logic        store_we;
    logic [3:0]  pos_inc;
    logic [3:0]  resync_pos;
    logic [15:0] got_crc;
    logic        is_target;
    logic [31:0] idle_ms;

    assign pos_inc    = pos_reg + 4'd1;
    assign resync_pos = (rx_byte == SYNC_FIRST) ? 4'd1 : 4'd0;
    assign is_target  = (store_reg[3] == TYPE_TARGET);
    assign got_crc    = {rx_byte, (explen_reg == VISION_SIZE) ? store_reg[13] : store_reg[9]};
    assign idle_ms    = now_ms - last_reg;

    always_comb
    begin
        pos_next    = pos_reg;
        explen_next = explen_reg;
        last_next   = last_reg;
        crc_next    = crc_reg;
        store_we    = 1'b0;
        job_valid   = 1'b0;
        job         = '0;
        if (in_valid)
        begin
            if (opcode == OP_TICK)
            begin
                if (pos_reg != 4'd0 && idle_ms >= {16'd0, timeout_ms})
                begin
                    pos_next    = 4'd0;
                    explen_next = 4'd0;
                end
            end
            else
            begin
                last_next = now_ms;
                if (pos_reg == 4'd0)
                begin
                    if (rx_byte == SYNC_FIRST)
                    begin
                        pos_next = 4'd1;
                    end
                end
                else if (pos_reg == 4'd1)
                begin
                    pos_next = (rx_byte == SYNC_SECOND) ? 4'd2 : resync_pos;
                end
                else if (pos_reg == POS_LIMIT)
                begin
                    pos_next    = 4'd0;
                    explen_next = 4'd0;
                end
                else
                begin
                    store_we = 1'b1;
                    pos_next = pos_inc;
                    // CRC covers byte 2 through the third byte from the end
                    if (pos_reg == 4'd2)
                    begin
                        crc_next = crc16_byte(CRC_INIT, rx_byte);
                    end
                    else if (pos_reg < HEADER_END ||
                             (explen_reg != 4'd0 && pos_reg < explen_reg - 4'd2))
                    begin
                        crc_next = crc16_byte(crc_reg, rx_byte);
                    end

                    if (pos_inc == HEADER_END)
                    begin
                        if (store_reg[2] != PROTO_VERSION)
                        begin
                            pos_next = resync_pos;
                        end
                        else if (store_reg[3] == TYPE_VISION && rx_byte == 8'(LEN_VISION))
                        begin
                            explen_next = VISION_SIZE;
                        end
                        else if (store_reg[3] == TYPE_TARGET && rx_byte == 8'(LEN_TARGET))
                        begin
                            explen_next = TARGET_SIZE;
                        end
                        else
                        begin
                            pos_next = resync_pos;
                            if (store_reg[3] == TYPE_TARGET)
                            begin
                                job_valid = 1'b1;
                                job.kind  = EV_TARGET_FMT;
                            end
                        end
                    end
                    else if (explen_reg != 4'd0 && pos_inc == explen_reg)
                    begin
                        pos_next    = 4'd0;
                        explen_next = 4'd0;
                        job_valid   = 1'b1;
                        if (got_crc != crc_reg)
                        begin
                            job.kind = is_target ? EV_TARGET_CRC : EV_VISION_CRC;
                        end
                        else if (is_target)
                        begin
                            job.kind = EV_TARGET_OK;
                            job.seq  = {store_reg[6], store_reg[5]};
                            job.pos  = {store_reg[8], store_reg[7]};
                        end
                        else
                        begin
                            job.kind  = EV_VISION_OK;
                            job.seq   = {store_reg[6], store_reg[5]};
                            job.flags = store_reg[7];
                            job.conf  = store_reg[8];
                            job.pos   = {store_reg[10], store_reg[9]};
                            job.vel   = {store_reg[12], store_reg[11]};
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 4'd0;
            explen_reg <= 4'd0;
            last_reg   <= 32'd0;
            crc_reg    <= CRC_INIT;
        end
        else
        begin
            pos_reg    <= pos_next;
            explen_reg <= explen_next;
            last_reg   <= last_next;
            crc_reg    <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[pos_reg] <= rx_byte;
        end
    end

endmodule

/* rtl/sfcrc_back.sv */
// Per-stream counters: sequence gaps, valid streak, error and update counts.
module sfcrc_back
    import sfcrc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    job_valid,
    input  job_t    job,
    input  logic    res_ready,
    output logic    job_pop,
    output logic    res_valid,
    output result_t res
);

    logic        v_seen_reg, v_seen_next;
    logic [15:0] v_last_reg, v_last_next;
    logic [15:0] v_drops_reg, v_drops_next;
    logic [15:0] v_crc_reg, v_crc_next;
    logic [7:0]  v_streak_reg, v_streak_next;
    logic        t_seen_reg, t_seen_next;
    logic [15:0] t_last_reg, t_last_next;
    logic [15:0] t_drops_reg, t_drops_next;
    logic [15:0] t_crc_reg, t_crc_next;
    logic [15:0] t_fmt_reg, t_fmt_next;
    logic [15:0] t_upd_reg, t_upd_next;
    logic        take;
    logic        valid_bit;

    assign take      = job_valid && res_ready;
    assign job_pop   = take;
    assign res_valid = take;
    assign valid_bit = job.flags[0];

    always_comb
    begin
        v_seen_next   = v_seen_reg;
        v_last_next   = v_last_reg;
        v_drops_next  = v_drops_reg;
        v_crc_next    = v_crc_reg;
        v_streak_next = v_streak_reg;
        t_seen_next   = t_seen_reg;
        t_last_next   = t_last_reg;
        t_drops_next  = t_drops_reg;
        t_crc_next    = t_crc_reg;
        t_fmt_next    = t_fmt_reg;
        t_upd_next    = t_upd_reg;
        if (take)
        begin
            unique case (job.kind)
                EV_VISION_OK:
                begin
                    // an in-order sequence adds zero to the gap count
                    if (v_seen_reg)
                    begin
                        v_drops_next = v_drops_reg + job.seq - v_last_reg - 16'd1;
                    end
                    v_seen_next = 1'b1;
                    v_last_next = job.seq;
                    if (!valid_bit)
                    begin
                        v_streak_next = 8'd0;
                    end
                    else if (v_streak_reg != STREAK_MAX)
                    begin
                        v_streak_next = v_streak_reg + 8'd1;
                    end
                end
                EV_TARGET_OK:
                begin
                    if (t_seen_reg)
                    begin
                        t_drops_next = t_drops_reg + job.seq - t_last_reg - 16'd1;
                    end
                    t_seen_next = 1'b1;
                    t_last_next = job.seq;
                    t_upd_next  = t_upd_reg + 16'd1;
                end
                EV_VISION_CRC: v_crc_next = v_crc_reg + 16'd1;
                EV_TARGET_CRC: t_crc_next = t_crc_reg + 16'd1;
                EV_TARGET_FMT: t_fmt_next = t_fmt_reg + 16'd1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        res            = '0;
        res.event_kind = job.kind;
        if (job.kind == EV_VISION_OK || job.kind == EV_VISION_CRC)
        begin
            res.sequence_drop_count = v_drops_next;
            res.crc_error_count     = v_crc_next;
        end
        else
        begin
            res.sequence_drop_count = t_drops_next;
            res.crc_error_count     = t_crc_next;
            res.format_error_count  = t_fmt_next;
            res.update_count        = t_upd_next;
        end
        if (job.kind == EV_VISION_OK)
        begin
            res.sequence_res = job.seq;
            res.frame_flags  = job.flags;
            res.confidence   = job.conf;
            res.position_q4  = job.pos;
            res.velocity     = job.vel;
            res.sample_valid = valid_bit;
            res.valid_streak = v_streak_next;
        end
        else if (job.kind == EV_TARGET_OK)
        begin
            res.sequence_res = job.seq;
            res.position_q4  = job.pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_seen_reg   <= 1'b0;
            v_last_reg   <= 16'd0;
            v_drops_reg  <= 16'd0;
            v_crc_reg    <= 16'd0;
            v_streak_reg <= 8'd0;
            t_seen_reg   <= 1'b0;
            t_last_reg   <= 16'd0;
            t_drops_reg  <= 16'd0;
            t_crc_reg    <= 16'd0;
            t_fmt_reg    <= 16'd0;
            t_upd_reg    <= 16'd0;
        end
        else
        begin
            v_seen_reg   <= v_seen_next;
            v_last_reg   <= v_last_next;
            v_drops_reg  <= v_drops_next;
            v_crc_reg    <= v_crc_next;
            v_streak_reg <= v_streak_next;
            t_seen_reg   <= t_seen_next;
            t_last_reg   <= t_last_next;
            t_drops_reg  <= t_drops_next;
            t_crc_reg    <= t_crc_next;
            t_fmt_reg    <= t_fmt_next;
            t_upd_reg    <= t_upd_next;
        end
    end

endmodule

/* rtl/sync_frame_crc16_receiver_unit.sv */
// Sync-word frame receiver with CRC-16 check and per-stream statistics.
//
// Input channel: drive opcode/rx_byte/now_ms with push; a transaction completes
// on a clock edge with push high and full low. opcode 0 carries one received
// byte, opcode 1 is a timeout check against the timeout register.
// Result channel: while empty is low the oldest result sits on the result
// ports; pop with empty low completes the transaction.
// One input transaction per cycle is taken while full stays low. A frame's
// job is written to the job queue at the edge that takes its last byte; the
// counter stage then writes its result to the result queue, from which it
// reaches the result ports. Every byte is parsed in the cycle it is taken;
// the header and payload bytes are also folded into the running CRC.
// When pop is held low the result queue fills, the counter stage stops and
// the job queue fills; full then rises and holds input off. Bytes keep
// flowing while only one of the queues is occupied.
// cfg_write loads cfg_data into the timeout register at the clock edge.
// Reset clears the parser to hunting, all counters to zero, both queues to
// empty and the timeout to 50 ms. No clearing pass is needed.
module sync_frame_crc16_receiver_unit
    import sfcrc_pkg::*;
#(
    parameter int JOB_DEPTH    = 2,
    parameter int RESULT_DEPTH = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               opcode,
    input  logic [7:0]         rx_byte,
    input  logic [31:0]        now_ms,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         event_kind,
    output logic [15:0]        sequence_res,
    output logic [7:0]         frame_flags,
    output logic [7:0]         confidence,
    output logic [15:0]        position_q4,
    output logic signed [15:0] velocity,
    output logic               sample_valid,
    output logic [7:0]         valid_streak,
    output logic [15:0]        sequence_drop_count,
    output logic [15:0]        crc_error_count,
    output logic [15:0]        format_error_count,
    output logic [15:0]        update_count,
    input  logic               cfg_write,
    input  logic [15:0]        cfg_data
);

    localparam int JOB_W = $bits(job_t);
    localparam int RES_W = $bits(result_t);

    logic [15:0]      timeout_reg;
    logic             in_valid;
    logic             job_push;
    job_t             job_in;
    logic [JOB_W-1:0] job_vec;
    job_t             job_out;
    logic             job_full;
    logic             job_empty;
    logic             job_pop;
    logic             res_push;
    result_t          res_in;
    logic [RES_W-1:0] res_vec;
    result_t          res_out;
    logic             res_full;

    assign full     = job_full;
    assign in_valid = push && !job_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= 16'd50;
        end
        else if (cfg_write)
        begin
            timeout_reg <= cfg_data;
        end
    end

    sfcrc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .opcode     (opcode),
        .rx_byte    (rx_byte),
        .now_ms     (now_ms),
        .timeout_ms (timeout_reg),
        .job_valid  (job_push),
        .job        (job_in)
    );

    sfcrc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_vec),
        .full    (job_full),
        .empty   (job_empty)
    );

    assign job_out = job_t'(job_vec);

    sfcrc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job       (job_out),
        .res_ready (!res_full),
        .job_pop   (job_pop),
        .res_valid (res_push),
        .res       (res_in)
    );

    sfcrc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_vec),
        .full    (res_full),
        .empty   (empty)
    );

    assign res_out             = result_t'(res_vec);
    assign event_kind          = res_out.event_kind;
    assign sequence_res        = res_out.sequence_res;
    assign frame_flags         = res_out.frame_flags;
    assign confidence          = res_out.confidence;
    assign position_q4         = res_out.position_q4;
    assign velocity            = res_out.velocity;
    assign sample_valid        = res_out.sample_valid;
    assign valid_streak        = res_out.valid_streak;
    assign sequence_drop_count = res_out.sequence_drop_count;
    assign crc_error_count     = res_out.crc_error_count;
    assign format_error_count  = res_out.format_error_count;
    assign update_count        = res_out.update_count;

    // a parser job only comes from a byte taken while the job queue had room
    a_job_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (in_valid && !job_full))
        else $error("job pushed into a full queue");

    // timeout checks never produce a job
    a_tick_no_job: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && opcode == OP_TICK) |-> !job_push)
        else $error("timeout tick produced a job");

    // the counter stage only advances when the result queue has room
    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!res_full && job_pop && !job_empty))
        else $error("result pushed into a full queue");

endmodule
